@@ rtl/stli_pkg.sv @@
package stli_pkg;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EXACT = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] y_result;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_Q_RD,
      S_Q_CMP,
      S_Q_PREV,
      S_Q_PREV_W,
      S_Q_MUL,
      S_Q_DIV_INIT,
      S_Q_DIV,
      S_Q_SUM,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clr_cnt;
      logic inc_cnt;
      logic set_pos_cnt;
      logic set_pos_zero;
      logic dec_pos;
      logic inc_pos;
      logic rd_pos;
      logic rd_prev;
      logic shift_wr;
      logic ins_wr;
      logic keep_hi;
      logic keep_lo;
      logic mul;
      logic div_start;
      logic div_step;
      logic sum;
      logic set_status;
      logic [1:0] status;
      logic use_y;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       pos_zero;
      logic       pos_at_cnt;
      logic       x_gt;
      logic       x_eq;
      logic       den_pos;
      logic       div_done;
   } sts_type;

endpackage

@@ rtl/stli_datapath.sv @@
module stli_datapath #(
   parameter int MAX_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  stli_pkg::req_type req,
   input  stli_pkg::cmd_type cmd,
   output stli_pkg::sts_type sts,
   output logic             rsp_strobe,
   output stli_pkg::rsp_type rsp
);
   import stli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [15:0] x_mem [MAX_POINTS];
   logic [15:0] y_mem [MAX_POINTS];

   req_type req_ff;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in;
   logic [15:0] xr_ff, yr_ff;
   logic signed [15:0] xc_ff, yc_ff, xa_ff, ya_ff;
   logic signed [33:0] num_ff;
   logic [32:0] rem_ff;
   logic [32:0] quo_ff;
   logic [16:0] den_ff;
   logic neg_ff;
   logic [5:0] dcnt_ff;
   logic [15:0] yres_ff;
   logic [1:0] st_ff;
   logic strobe_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [CW-1:0] prev_pos;
   logic [33:0] rem_sh;
   logic signed [17:0] dy;
   logic signed [17:0] dx;
   logic signed [34:0] sum_v;
   logic signed [33:0] quo_s;

   assign prev_pos = pos_ff - CW'(1);

   always_comb begin
      rd_addr = AW'(pos_ff);
      if (cmd.rd_prev) begin
         rd_addr = AW'(prev_pos);
      end
      wr_addr = AW'(pos_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_pos || cmd.rd_prev) begin
         xr_ff <= x_mem[rd_addr];
         yr_ff <= y_mem[rd_addr];
      end
      if (cmd.shift_wr) begin
         x_mem[wr_addr] <= xr_ff;
         y_mem[wr_addr] <= yr_ff;
      end else if (cmd.ins_wr) begin
         x_mem[wr_addr] <= req_ff.x_value;
         y_mem[wr_addr] <= req_ff.y_value;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clr_cnt) begin
         cnt_in = '0;
      end else if (cmd.inc_cnt) begin
         cnt_in = cnt_ff + CW'(1);
      end
      pos_in = pos_ff;
      if (cmd.set_pos_cnt) begin
         pos_in = cnt_ff;
      end else if (cmd.set_pos_zero) begin
         pos_in = '0;
      end else if (cmd.dec_pos) begin
         pos_in = prev_pos;
      end else if (cmd.inc_pos) begin
         pos_in = pos_ff + CW'(1);
      end
   end

   assign dy = 18'(yc_ff) - 18'(ya_ff);
   assign dx = 18'(req_ff.x_value) - 18'(xa_ff);
   assign rem_sh = {rem_ff, quo_ff[32]};
   assign quo_s = neg_ff ? -34'(quo_ff) : 34'(quo_ff);
   assign sum_v = 35'(ya_ff) + 35'(quo_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         strobe_ff <= cmd.emit;
      end
      pos_ff <= pos_in;
      if (cmd.load_req) begin
         req_ff <= req;
      end
      if (cmd.keep_hi) begin
         xc_ff <= xr_ff;
         yc_ff <= yr_ff;
      end
      if (cmd.keep_lo) begin
         xa_ff <= xr_ff;
         ya_ff <= yr_ff;
      end
      if (cmd.mul) begin
         num_ff <= 34'(dx * dy);
         den_ff <= 17'(18'(xc_ff) - 18'(xa_ff));
      end
      if (cmd.div_start) begin
         neg_ff <= num_ff[33];
         quo_ff <= num_ff[33] ? 33'(-num_ff) : 33'(num_ff);
         rem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= 34'(den_ff)) begin
            rem_ff <= 33'(rem_sh - 34'(den_ff));
            quo_ff <= {quo_ff[31:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[32:0];
            quo_ff <= {quo_ff[31:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
      if (cmd.set_status) begin
         st_ff <= cmd.status;
      end
      if (cmd.sum) begin
         if (sum_v > 35'sd32767) begin
            yres_ff <= 16'h7fff;
         end else if (sum_v < -35'sd32768) begin
            yres_ff <= 16'h8000;
         end else begin
            yres_ff <= sum_v[15:0];
         end
      end else if (cmd.set_status) begin
         if (cmd.use_y) begin
            yres_ff <= yr_ff;
         end else begin
            yres_ff <= '0;
         end
      end
   end

   always_comb begin
      sts.kind = req_ff.kind;
      sts.full = (cnt_ff >= CW'(MAX_POINTS));
      sts.pos_zero = (pos_ff == '0);
      sts.pos_at_cnt = (pos_ff == cnt_ff);
      sts.x_gt = $signed(xr_ff) > req_ff.x_value;
      sts.x_eq = $signed(xr_ff) == req_ff.x_value;
      sts.den_pos = $signed(xc_ff) > xa_ff;
      sts.div_done = (dcnt_ff == 6'd33);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp.y_result = yres_ff;
   assign rsp.status = st_ff;
endmodule

@@ rtl/stli_ctrl.sv @@
module stli_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stli_pkg::sts_type sts,
   output stli_pkg::cmd_type cmd
);
   import stli_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
            if (sts.kind == KIND_LOAD && !sts.full) begin
               state_in = S_INS_RD;
            end else if (sts.kind == KIND_QUERY) begin
               state_in = S_Q_RD;
            end
         end
         S_INS_RD: state_in = sts.pos_zero ? S_IDLE : S_INS_CMP;
         S_INS_CMP: begin
            if (sts.x_gt && !sts.pos_zero) state_in = S_INS_RD;
            else state_in = S_IDLE;
         end
         S_Q_RD: state_in = sts.pos_at_cnt ? S_IDLE : S_Q_CMP;
         S_Q_CMP: begin
            if (sts.x_eq) state_in = S_IDLE;
            else if (sts.x_gt) state_in = sts.pos_zero ? S_IDLE : S_Q_PREV;
            else state_in = S_Q_RD;
         end
         S_Q_PREV: state_in = S_Q_PREV_W;
         S_Q_PREV_W: state_in = S_Q_MUL;
         S_Q_MUL: state_in = sts.den_pos ? S_Q_DIV_INIT : S_IDLE;
         S_Q_DIV_INIT: state_in = S_Q_DIV;
         S_Q_DIV: state_in = sts.div_done ? S_Q_SUM : S_Q_DIV;
         S_Q_SUM: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = start;
         end
         S_DONE: begin
            unique case (sts.kind)
               KIND_LOAD: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status = ST_FULL;
                     cmd.emit = 1'b1;
                  end else begin
                     cmd.set_pos_cnt = 1'b1;
                     cmd.inc_cnt = 1'b1;
                  end
               end
               KIND_QUERY: cmd.set_pos_zero = 1'b1;
               KIND_CLEAR: begin
                  cmd.clr_cnt = 1'b1;
                  cmd.set_status = 1'b1;
                  cmd.status = ST_OK;
                  cmd.emit = 1'b1;
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_RANGE;
                  cmd.emit = 1'b1;
               end
            endcase
         end
         S_INS_RD: begin
            if (sts.pos_zero) begin
               cmd.ins_wr = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status = ST_OK;
               cmd.emit = 1'b1;
            end else begin
               cmd.rd_prev = 1'b1;
            end
         end
         S_INS_CMP: begin
            if (sts.x_gt) begin
               cmd.shift_wr = 1'b1;
               cmd.dec_pos = 1'b1;
               if (sts.pos_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_OK;
                  cmd.emit = 1'b1;
               end
            end else begin
               cmd.ins_wr = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status = ST_OK;
               cmd.emit = 1'b1;
            end
         end
         S_Q_RD: begin
            if (sts.pos_at_cnt) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_RANGE;
               cmd.emit = 1'b1;
            end else begin
               cmd.rd_pos = 1'b1;
            end
         end
         S_Q_CMP: begin
            if (sts.x_eq) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_EXACT;
               cmd.use_y = 1'b1;
               cmd.emit = 1'b1;
            end else if (sts.x_gt) begin
               cmd.keep_hi = 1'b1;
               if (sts.pos_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_RANGE;
                  cmd.emit = 1'b1;
               end
            end else begin
               cmd.inc_pos = 1'b1;
            end
         end
         S_Q_PREV: cmd.rd_prev = 1'b1;
         S_Q_PREV_W: cmd.keep_lo = 1'b1;
         S_Q_MUL: begin
            if (sts.den_pos) begin
               cmd.mul = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status = ST_RANGE;
               cmd.emit = 1'b1;
            end
         end
         S_Q_DIV_INIT: cmd.div_start = 1'b1;
         S_Q_DIV: begin
            cmd.div_step = sts.div_done ? 1'b0 : 1'b1;
         end
         S_Q_SUM: begin
            cmd.sum = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status = ST_OK;
            cmd.emit = 1'b1;
         end
         default: cmd = '0;
      endcase
      if (state_ff == S_Q_MUL && sts.den_pos) begin
         cmd.mul = 1'b1;
      end
   end
endmodule

@@ rtl/sorted_table_linear_interpolator_core.sv @@
// A request is taken when start is high and busy is low; one response follows per request.
// Clear and rejected requests are answered from the decode state; a load reads and shifts up each larger
// entry in turn, then writes the new point in the freed slot, at the front of the table if all are larger.
// A query scans entries from the front; interpolation adds a multiply and the 33-step divider.
// One request is in flight at a time; the response strobe lasts one cycle and cannot stall.
// Synchronous reset empties the table; table memory contents are left undefined.
module sorted_table_linear_interpolator_core #(
   parameter int MAX_POINTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  stli_pkg::req_type req_data,
   output logic              rsp_strobe,
   output stli_pkg::rsp_type rsp_data
);
   import stli_pkg::*;

   cmd_type cmd;
   sts_type sts;

   stli_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   stli_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );
endmodule
